>>> src/fra_pkg.sv
`timescale 1ns / 1ps

package fra_pkg;

  // Request kinds carried on the input user bits, above the byte count in a request
  typedef enum logic [1:0] {
    CMD_ALIGNED     = 2'd0,
    CMD_UNALIGNED   = 2'd1,
    CMD_START_FRAME = 2'd2,
    CMD_RESET       = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_UNALIGNED_WRAP = 3'd1,
    ST_NO_FRAME       = 3'd2,
    ST_STOMP          = 3'd3,
    ST_TOO_LARGE      = 3'd4
  } status_t;

  // One request as it travels down the pipeline
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] byte_count;
  } req_t;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_SIZE = 1'd0;
  localparam logic [31:0] BUFFER_SIZE_RESET = 32'd65536;

  // Largest span the allocator works with
  localparam logic [32:0] MAX_SPAN = 33'h0_FFFF_FFFF;

endpackage

>>> src/fra_cfg.sv
`timescale 1ns / 1ps

module fra_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic [31:0] buffer_size
);

  logic [31:0] buffer_size_r;
  logic        wr_hit;

  assign cfg_pready = 1'b1;
  assign wr_hit = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[2] == fra_pkg::REG_BUFFER_SIZE);

  // Write the ring size on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_size_r <= fra_pkg::BUFFER_SIZE_RESET;
    end else if (wr_hit) begin
      buffer_size_r <= cfg_pwdata;
    end
  end

  // Return the register on a read; unmapped addresses read zero
  always_comb begin
    if (cfg_paddr[2] == fra_pkg::REG_BUFFER_SIZE) begin
      cfg_prdata = buffer_size_r;
    end else begin
      cfg_prdata = 32'd0;
    end
  end

  assign buffer_size = buffer_size_r;

endmodule

>>> src/fra_modpipe.sv
`timescale 1ns / 1ps

module fra_modpipe #(
  parameter int unsigned ALIGN_BYTES = 256,
  localparam int unsigned REM_W = $clog2(ALIGN_BYTES)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fra_pkg::req_t        in_req,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fra_pkg::req_t        out_req,
  output logic [REM_W-1:0]     out_rem
);

  // Reciprocal of the alignment, scaled so the quotient is exact or one low
  localparam int unsigned SHIFT = 32 + REM_W;
  localparam logic [33:0] RECIP = 34'((64'd1 << SHIFT) / ALIGN_BYTES);
  localparam logic [31:0] ALIGN_W = 32'(ALIGN_BYTES);

  logic                s1_valid_r;
  fra_pkg::req_t       s1_req_r;
  logic [31:0]         s1_quot_r;
  logic                s2_valid_r;
  fra_pkg::req_t       s2_req_r;
  logic [REM_W-1:0]    s2_rem_r;

  logic                s1_ready;
  logic                s2_ready;
  logic [65:0]         quot_prod;
  logic [31:0]         quot_nxt;
  logic [47:0]         back_prod;
  logic [31:0]         rem_est;
  logic [31:0]         rem_fix;

  assign s2_ready = !s2_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // Stage one: estimate the quotient of the byte count
  assign quot_prod = 66'(in_req.byte_count) * 66'(RECIP);
  assign quot_nxt  = 32'(quot_prod >> SHIFT);

  // Stage two: remainder from the estimate, one correction step
  assign back_prod = 48'(s1_quot_r) * 48'(ALIGN_W);
  assign rem_est   = s1_req_r.byte_count - back_prod[31:0];
  always_comb begin
    if (rem_est >= ALIGN_W) begin
      rem_fix = rem_est - ALIGN_W;
    end else begin
      rem_fix = rem_est;
    end
  end

  // Advance the stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // Hold or load the stage payloads
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_req_r  <= in_req;
      s1_quot_r <= quot_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      s2_req_r <= s1_req_r;
      s2_rem_r <= rem_fix[REM_W-1:0];
    end
  end

  assign out_valid = s2_valid_r;
  assign out_req   = s2_req_r;
  assign out_rem   = s2_rem_r;

endmodule

>>> src/fra_core.sv
`timescale 1ns / 1ps

module fra_core #(
  parameter int unsigned ALIGN_BYTES = 256,
  parameter int unsigned FRAMES_IN_FLIGHT = 4,
  localparam int unsigned REM_W = $clog2(ALIGN_BYTES),
  localparam int unsigned CNT_W = $clog2(FRAMES_IN_FLIGHT + 1),
  localparam int unsigned IDX_W = (FRAMES_IN_FLIGHT > 1) ? $clog2(FRAMES_IN_FLIGHT) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [31:0]          buffer_size,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  fra_pkg::req_t        req,
  input  logic [REM_W-1:0]     req_rem,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_offset,
  output fra_pkg::status_t     out_status
);

  localparam logic [REM_W:0]  ALIGN_R = (REM_W + 1)'(ALIGN_BYTES);
  localparam logic [32:0]     ALIGN_P = 33'(ALIGN_BYTES);
  localparam logic [31:0]     LIMIT   = 32'(fra_pkg::MAX_SPAN - 33'(2 * ALIGN_BYTES));
  localparam logic [CNT_W-1:0] FULL   = CNT_W'(FRAMES_IN_FLIGHT);

  logic [31:0]        cur_r;
  logic [REM_W-1:0]   rem_r;
  logic [CNT_W-1:0]   count_r;
  logic [31:0]        newest_r;
  logic [31:0]        hist_r [FRAMES_IN_FLIGHT];
  logic               out_valid_r;
  logic [31:0]        offset_r;
  fra_pkg::status_t   status_r;

  logic               take;
  logic               is_write;
  logic               aligned;
  logic               too_large;
  logic [32:0]        pos;
  logic [33:0]        end_sum;
  logic               wrap;
  logic [31:0]        new_off;
  logic [REM_W-1:0]   rem_base;
  logic [REM_W:0]     rem_sum;
  logic [REM_W:0]     rem_new;
  logic [31:0]        offset_nxt;
  fra_pkg::status_t   status_nxt;
  logic               commit;

  assign req_ready = !out_valid_r || out_ready;
  assign take      = req_valid && req_ready;

  // Decode the request and check its size
  assign is_write  = (req.cmd == fra_pkg::CMD_ALIGNED) ||
                     (req.cmd == fra_pkg::CMD_UNALIGNED);
  assign aligned   = (req.cmd == fra_pkg::CMD_ALIGNED);
  assign too_large = (req.byte_count >= LIMIT) || (req.byte_count > buffer_size);

  // Round up to the alignment, then wrap to zero if the span does not fit
  always_comb begin
    if (aligned && (rem_r != '0)) begin
      pos = {1'b0, cur_r} + (ALIGN_P - 33'(rem_r));
    end else begin
      pos = {1'b0, cur_r};
    end
  end
  assign end_sum = {1'b0, pos} + 34'(req.byte_count);
  assign wrap    = (pos >= {1'b0, buffer_size}) || (end_sum > {2'b0, buffer_size});
  assign new_off = wrap ? req.byte_count : end_sum[31:0];

  // Track the new offset modulo the alignment
  assign rem_base = (wrap || aligned) ? '0 : rem_r;
  assign rem_sum  = {1'b0, rem_base} + {1'b0, req_rem};
  assign rem_new  = (rem_sum >= ALIGN_R) ? (rem_sum - ALIGN_R) : rem_sum;

  // Pick the result and status
  always_comb begin
    offset_nxt = 32'd0;
    status_nxt = fra_pkg::ST_OK;
    commit     = 1'b0;
    if (is_write) begin
      if (too_large) begin
        status_nxt = fra_pkg::ST_TOO_LARGE;
      end else begin
        commit     = 1'b1;
        offset_nxt = wrap ? 32'd0 : pos[31:0];
        if (wrap && !aligned) begin
          status_nxt = fra_pkg::ST_UNALIGNED_WRAP;
        end else if (count_r == '0) begin
          status_nxt = fra_pkg::ST_NO_FRAME;
        end else if (!((newest_r < new_off) || (hist_r[0] > new_off))) begin
          status_nxt = fra_pkg::ST_STOMP;
        end
      end
    end
  end

  // Update the running offset and frame count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= 32'd0;
      rem_r   <= '0;
      count_r <= '0;
    end else if (take) begin
      if (req.cmd == fra_pkg::CMD_RESET) begin
        cur_r   <= 32'd0;
        rem_r   <= '0;
        count_r <= '0;
      end else if (req.cmd == fra_pkg::CMD_START_FRAME) begin
        if (count_r < FULL) begin
          count_r <= count_r + CNT_W'(1);
        end
      end else if (commit) begin
        cur_r <= new_off;
        rem_r <= rem_new[REM_W-1:0];
      end
    end
  end

  // Push frame starts; drop the oldest once the history is full
  always_ff @(posedge clk) begin
    if (take && (req.cmd == fra_pkg::CMD_START_FRAME)) begin
      newest_r <= cur_r;
      if (count_r < FULL) begin
        for (int i = 0; i < FRAMES_IN_FLIGHT; i++) begin
          if (IDX_W'(i) == count_r[IDX_W-1:0]) begin
            hist_r[i] <= cur_r;
          end
        end
      end else begin
        for (int i = 0; i < FRAMES_IN_FLIGHT - 1; i++) begin
          hist_r[i] <= hist_r[i + 1];
        end
        hist_r[FRAMES_IN_FLIGHT - 1] <= cur_r;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req_ready) begin
      out_valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      offset_r <= offset_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_offset = offset_r;
  assign out_status = status_r;

`ifndef SYNTH
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rem_r) < 32'(ALIGN_BYTES))
    else $error("offset remainder out of range");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("frame history count overflow");

  a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (req.cmd == fra_pkg::CMD_RESET)) |=>
      (cur_r == 32'd0) && (rem_r == '0) && (count_r == '0))
    else $error("reset request did not clear the ring");

  a_rejected_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (take && is_write && too_large) |=> (cur_r == $past(cur_r)) && (offset_r == 32'd0))
    else $error("oversized request changed state");
`endif

endmodule

>>> src/frame_ring_allocator.sv
`timescale 1ns / 1ps

// Ring offset allocator for per-frame upload space. Each input request is a
// 2-bit command and a 32-bit byte count; every request yields exactly one
// result carrying the allocated offset and a status. The block takes one
// request per clock while the result side does not stall: a registered
// quotient estimate and a registered remainder correction compute the byte
// count modulo ALIGN_BYTES by a reciprocal multiply, and the running offset
// is updated by an align, compare and add that feeds the result register.
// Stalls on the result side hold the pipeline. The history of frame starts
// holds FRAMES_IN_FLIGHT entries and needs no clearing pass after reset.
// Write buffer_size (address 0) only while no request is in flight.
module frame_ring_allocator #(
  parameter int unsigned ALIGN_BYTES = 256,
  parameter int unsigned FRAMES_IN_FLIGHT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: [31:0] byte_count
  input  logic [31:0] in_tdata,
  // in_tuser: [1:0] cmd
  input  logic [1:0]  in_tuser,
  // out_tdata: [31:0] write_offset, [34:32] status, [39:35] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned REM_W = $clog2(ALIGN_BYTES);

  logic [31:0]        buffer_size;
  fra_pkg::req_t      in_req;
  logic               mid_valid;
  logic               mid_ready;
  fra_pkg::req_t      mid_req;
  logic [REM_W-1:0]   mid_rem;
  logic [31:0]        res_offset;
  fra_pkg::status_t   res_status;

  // Unpack the request
  assign in_req = {fra_pkg::cmd_t'(in_tuser), in_tdata};

  fra_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .buffer_size (buffer_size)
  );

  fra_modpipe #(
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_modpipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_req),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_req   (mid_req),
    .out_rem   (mid_rem)
  );

  fra_core #(
    .ALIGN_BYTES      (ALIGN_BYTES),
    .FRAMES_IN_FLIGHT (FRAMES_IN_FLIGHT)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .buffer_size (buffer_size),
    .req_valid   (mid_valid),
    .req_ready   (mid_ready),
    .req         (mid_req),
    .req_rem     (mid_rem),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_offset  (res_offset),
    .out_status  (res_status)
  );

  // Pack the result
  assign out_tdata = {5'd0, res_status, res_offset};

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ALIGN_BYTES = 256;
  localparam int unsigned FRAMES = 4;
  localparam logic [63:0] ALIGN_W = 64'(ALIGN_BYTES);
  localparam logic [63:0] SPAN_LIMIT = 64'hFFFF_FFFF;
  localparam logic [2:0] ADDR_BUFFER_SIZE = {fra_pkg::REG_BUFFER_SIZE, 2'b00};
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;

  // Expected grant for one request
  typedef struct {
    logic [31:0]      offset;
    fra_pkg::status_t status;
  } grant_t;

  // Mirror of the allocator state, with the grants still owed by the block
  class alloc_tracker;
    logic [31:0] ring_size;
    logic [31:0] cur_offset;
    logic [31:0] frame_starts [FRAMES];
    int unsigned frame_count;
    grant_t      pending_grants [$];
    int unsigned mismatches;
    int unsigned grants_seen;
    int unsigned status_hits [5];

    function void clear_ring();
      cur_offset = '0;
      frame_count = 0;
      foreach (frame_starts[i]) frame_starts[i] = '0;
    endfunction

    function void power_on();
      ring_size = fra_pkg::BUFFER_SIZE_RESET;
      clear_ring();
    endfunction

    // Push the running offset, shifting out the oldest start when full
    function void push_frame();
      int i;
      if (frame_count < FRAMES) begin
        frame_starts[frame_count] = cur_offset;
        frame_count++;
      end else begin
        for (i = 0; i < FRAMES - 1; i++) frame_starts[i] = frame_starts[i + 1];
        frame_starts[FRAMES - 1] = cur_offset;
      end
    endfunction

    // Work out the grant for an accepted request and advance the mirror
    function void note_request(fra_pkg::cmd_t cmd, logic [31:0] bc);
      grant_t      g;
      logic [63:0] pos;
      logic [63:0] rs;
      logic [63:0] cnt;
      bit          aligned;
      g.offset = '0;
      g.status = fra_pkg::ST_OK;
      rs = {32'd0, ring_size};
      cnt = {32'd0, bc};
      case (cmd)
        fra_pkg::CMD_START_FRAME: push_frame();
        fra_pkg::CMD_RESET: clear_ring();
        default: begin
          aligned = (cmd == fra_pkg::CMD_ALIGNED);
          if (cnt + ALIGN_W >= SPAN_LIMIT - ALIGN_W || cnt > rs) begin
            g.status = fra_pkg::ST_TOO_LARGE;
          end else begin
            pos = {32'd0, cur_offset};
            // round up to the next alignment boundary
            if (aligned && (pos % ALIGN_W) != 0) pos = pos + ALIGN_W - (pos % ALIGN_W);
            // wrap when the request does not fit before the end of the ring
            if (rs <= pos || rs - pos < cnt) begin
              if (!aligned) g.status = fra_pkg::ST_UNALIGNED_WRAP;
              pos = '0;
            end
            g.offset = pos[31:0];
            cur_offset = pos[31:0] + bc;
            if (g.status == fra_pkg::ST_OK) begin
              if (frame_count == 0) begin
                g.status = fra_pkg::ST_NO_FRAME;
              end else if (!(frame_starts[frame_count - 1] < cur_offset ||
                             frame_starts[0] > cur_offset)) begin
                g.status = fra_pkg::ST_STOMP;
              end
            end
          end
        end
      endcase
      status_hits[g.status]++;
      pending_grants.insert(pending_grants.size(), g);
    endfunction

    // Compare a result with the oldest grant owed
    function void check_result(logic [31:0] offset, logic [2:0] status);
      grant_t g;
      grants_seen++;
      if (pending_grants.size() == 0) begin
        $error("unexpected result: write_offset %0d, status %0d", offset, status);
        mismatches++;
        return;
      end
      g = pending_grants.pop_front();
      if (offset !== g.offset) begin
        $error("write_offset: expected %0d, actual %0d", g.offset, offset);
        mismatches++;
      end
      if (status !== g.status) begin
        $error("status: expected %0d, actual %0d", g.status, status);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  alloc_tracker tracker;
  int unsigned  requests_sent;
  int           cycles;
  bit           sender_quiet;
  bit           receiver_quiet;
  bit           stall_burst_req;

  frame_ring_allocator #(
    .ALIGN_BYTES(ALIGN_BYTES),
    .FRAMES_IN_FLIGHT(FRAMES)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Check every result taken from the block
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata[31:0], out_tdata[34:32]);
  end

  // Result side: random stalls, quiet stretches and one long hold-off
  initial begin
    int stall;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = receiver_quiet ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 39) == 0) receiver_quiet = !receiver_quiet;
      if (stall_burst_req) begin
        stall_burst_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Offer one request after a random gap and hold it until accepted
  task automatic send_request(fra_pkg::cmd_t cmd, logic [31:0] bc);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 39) == 0) sender_quiet = !sender_quiet;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= bc;
    in_tuser <= cmd;
    do @(posedge clk); while (!in_tready);
    tracker.note_request(cmd, bc);
    requests_sent++;
  endtask

  // Mostly writes sized against the ring, with frame starts, resets and noise
  task automatic random_request();
    int            pick;
    logic [31:0]   bc;
    fra_pkg::cmd_t wr_cmd;
    pick = $urandom_range(0, 99);
    wr_cmd = ($urandom_range(0, 1) == 0) ? fra_pkg::CMD_ALIGNED : fra_pkg::CMD_UNALIGNED;
    if (pick < 15) begin
      send_request(fra_pkg::CMD_START_FRAME, $urandom);
    end else if (pick < 18) begin
      send_request(fra_pkg::CMD_RESET, $urandom);
    end else if (pick < 25) begin
      send_request(wr_cmd, $urandom);
    end else if (pick < 30) begin
      case ($urandom_range(0, 4))
        0: bc = tracker.ring_size;
        1: bc = tracker.ring_size + 32'd1;
        2: bc = 32'hFFFF_FDFE;
        3: bc = 32'hFFFF_FDFF;
        default: bc = '0;
      endcase
      send_request(wr_cmd, bc);
    end else begin
      bc = $urandom_range(0, tracker.ring_size >> $urandom_range(0, 8));
      send_request(wr_cmd, bc);
    end
  endtask

  // Drop valid and wait for every owed grant
  task automatic drain();
    in_tvalid <= 1'b0;
    while (tracker.pending_grants.size() > 0) @(posedge clk);
  endtask

  task automatic cfg_access(bit wr, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= ADDR_BUFFER_SIZE;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (!wr && cfg_prdata !== data) begin
      $error("buffer_size: expected %0d, actual %0d", data, cfg_prdata);
      tracker.mismatches++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write the ring size, read it back and update the mirror
  task automatic set_ring(logic [31:0] ring);
    cfg_access(1'b1, ring);
    tracker.ring_size = ring;
    cfg_access(1'b0, ring);
  endtask

  task automatic run_phase(logic [31:0] ring, int n, bit squeeze);
    drain();
    set_ring(ring);
    if (squeeze) begin
      sender_quiet = 1'b1;
      stall_burst_req = 1'b1;
    end
    repeat (n) random_request();
  endtask

  initial begin
    tracker = new();
    tracker.power_on();
    requests_sent = 0;
    cycles = 0;
    sender_quiet = 1'b0;
    receiver_quiet = 1'b0;
    stall_burst_req = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset value, then a small ring for the directed cases
    cfg_access(1'b0, fra_pkg::BUFFER_SIZE_RESET);
    set_ring(32'd4096);
    send_request(fra_pkg::CMD_ALIGNED, 32'd10);          // no frame started yet
    send_request(fra_pkg::CMD_UNALIGNED, 32'd0);
    send_request(fra_pkg::CMD_START_FRAME, 32'hFFFF_FFFF);
    send_request(fra_pkg::CMD_ALIGNED, 32'd100);
    send_request(fra_pkg::CMD_START_FRAME, 32'd0);
    send_request(fra_pkg::CMD_ALIGNED, 32'd4000);        // aligned wrap
    send_request(fra_pkg::CMD_ALIGNED, 32'd100);         // lands on an in-flight frame
    send_request(fra_pkg::CMD_UNALIGNED, 32'd4000);      // unaligned wrap
    send_request(fra_pkg::CMD_ALIGNED, 32'd4097);        // larger than the ring
    send_request(fra_pkg::CMD_ALIGNED, 32'hFFFF_FFFF);
    send_request(fra_pkg::CMD_UNALIGNED, 32'hFFFF_FDFF);
    send_request(fra_pkg::CMD_ALIGNED, 32'd4096);        // exactly the ring
    send_request(fra_pkg::CMD_UNALIGNED, 32'd0);         // offset at the end forces a wrap
    repeat (5) send_request(fra_pkg::CMD_START_FRAME, $urandom);  // overflow the history
    send_request(fra_pkg::CMD_UNALIGNED, 32'd5);
    send_request(fra_pkg::CMD_RESET, 32'hFFFF_FFFF);
    send_request(fra_pkg::CMD_ALIGNED, 32'd1);
    send_request(fra_pkg::CMD_UNALIGNED, 32'hFFFF_FDFE);
    send_request(fra_pkg::CMD_RESET, $urandom);

    run_phase(32'd65536, 400, 1'b1);

    // Largest ring: the size threshold for oversized writes
    drain();
    set_ring(32'hFFFF_FEFF);
    send_request(fra_pkg::CMD_START_FRAME, 32'd0);
    send_request(fra_pkg::CMD_ALIGNED, 32'hFFFF_FDFE);
    send_request(fra_pkg::CMD_UNALIGNED, 32'hFFFF_FDFF);
    send_request(fra_pkg::CMD_UNALIGNED, 32'd1);
    send_request(fra_pkg::CMD_ALIGNED, 32'hFFFF_0000);
    repeat (350) random_request();

    // Shrink below the running offset, then other sizes
    run_phase(32'd257, 400, 1'b0);
    run_phase($urandom_range(257, 32'hFFFF_FEFF), 400, 1'b0);
    run_phase(32'd1000, 400, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    $display("tb: %0d requests, %0d results over ring sizes 257 to 4294967039 and a long stall",
             requests_sent, tracker.grants_seen);
    $display("tb: status ok %0d, unaligned wrap %0d, no frame %0d, stomp %0d, too large %0d",
             tracker.status_hits[fra_pkg::ST_OK], tracker.status_hits[fra_pkg::ST_UNALIGNED_WRAP],
             tracker.status_hits[fra_pkg::ST_NO_FRAME], tracker.status_hits[fra_pkg::ST_STOMP],
             tracker.status_hits[fra_pkg::ST_TOO_LARGE]);
    if (tracker.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
